// ----- sv/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the scrolling bar matrix driver.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Number of display columns (default for the top-level parameter)
  localparam int COLUMNS_DEF = 8;

  // Input command codes
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam int          CFG_IDX_W      = 2;
  localparam logic [1:0]  CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0]  CFG_SCAN_ROWS  = 2'd1;
  localparam int          CFG_DATA_W     = 4;

  // Reset values of the configuration registers
  localparam logic [3:0] BRIGHTNESS_RST = 4'd8;
  localparam logic [2:0] SCAN_ROWS_RST  = 3'd7;

  // Controller register addresses
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'ha;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hb;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hc;
  localparam logic [3:0] ADDR_TEST      = 4'hf;

  // Header writes of the init sequence, by step
  localparam logic [1:0] HEAD_SCANLIMIT = 2'd0;
  localparam logic [1:0] HEAD_DECODE    = 2'd1;
  localparam logic [1:0] HEAD_SHUTDOWN  = 2'd2;
  localparam logic [1:0] HEAD_TEST      = 2'd3;

  // Input request
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] reading;
  } in_t;

  // Result request: one controller register write
  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } out_t;

  // Classified operation
  typedef enum logic [1:0] {
    OP_INIT,
    OP_SAMPLE,
    OP_CLEAR
  } op_t;

  // Entry of the command queue between front and back
  typedef struct packed {
    op_t        op;
    logic [2:0] level;
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COLS,
    ST_TAIL
  } st_t;

endpackage

// ----- sv/sbm_front.sv -----
// ----------------------------------------------------------------------------
// sbm_front
// Accepts input requests, classifies them and queues them for the sequencer.
// ----------------------------------------------------------------------------
module sbm_front import sbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic cmd_valid,
  output cmd_t cmd,
  input  logic cmd_take
);

  cmd_t       slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  cmd_t       entry;
  logic       keep;
  logic       do_push;
  logic       do_pop;

  // Classify the command; drop the unused code
  always_comb begin
    entry.level = item.reading[15:13];
    keep        = 1'b1;
    case (item.cmd)
      CMD_INIT:   entry.op = OP_INIT;
      CMD_SAMPLE: entry.op = OP_SAMPLE;
      CMD_CLEAR:  entry.op = OP_CLEAR;
      default: begin
        entry.op = OP_CLEAR;
        keep     = 1'b0;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full && keep;
  assign do_pop    = cmd_take && cmd_valid;

  // Store queued commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/sbm_back.sv -----
// ----------------------------------------------------------------------------
// sbm_back
// Sequencer: carries out queued commands, keeps the column ring and emits
// one register write per cycle into a two-entry result queue, when not full.
// ----------------------------------------------------------------------------
module sbm_back import sbm_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic [3:0] brightness,
  input  logic [2:0] scan_rows,
  output logic       empty,
  input  logic       pop,
  output out_t       result
);

  localparam int             CW       = $clog2(COLUMNS);
  localparam logic [CW-1:0]  LAST_COL = CW'(COLUMNS - 1);

  st_t           state, state_next;
  op_t           op, op_next;
  logic [1:0]    step, step_next;
  logic [CW-1:0] col, col_next;
  logic [CW-1:0] rd, rd_next;
  logic [CW-1:0] wp, wp_next;
  logic [7:0]    store [COLUMNS];
  logic          store_we;
  logic [7:0]    store_wdata;

  out_t          oq [2];
  logic [1:0]    oq_count;
  logic          oq_wr;
  logic          oq_rd;
  logic          emit;
  logic          take_out;
  out_t          emit_item;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] x);
    return (x == LAST_COL) ? '0 : x + 1'b1;
  endfunction

  assign emit     = (state != ST_IDLE) && (oq_count != 2'd2);
  assign cmd_take = (state == ST_IDLE);
  assign take_out = pop && !empty;

  // Build the current register write
  always_comb begin
    emit_item = '0;
    case (state)
      ST_HEAD: begin
        case (step)
          HEAD_SCANLIMIT: begin
            emit_item.reg_addr = ADDR_SCANLIMIT;
            emit_item.reg_data = {5'd0, scan_rows};
          end
          HEAD_DECODE: begin
            emit_item.reg_addr = ADDR_DECODE;
          end
          HEAD_SHUTDOWN: begin
            emit_item.reg_addr = ADDR_SHUTDOWN;
            emit_item.reg_data = 8'd1;
          end
          default: begin
            emit_item.reg_addr = ADDR_TEST;
          end
        endcase
      end
      ST_COLS: begin
        emit_item.reg_addr = 4'(col) + 4'd1;
        emit_item.reg_data = (op == OP_SAMPLE) ? store[rd] : 8'h00;
        emit_item.last     = (op != OP_INIT) && (col == LAST_COL);
      end
      ST_TAIL: begin
        emit_item.reg_addr = ADDR_INTENSITY;
        emit_item.reg_data = {4'd0, brightness};
        emit_item.last     = 1'b1;
      end
      default: emit_item = '0;
    endcase
  end

  // Next state and ring update
  always_comb begin
    state_next  = state;
    op_next     = op;
    step_next   = step;
    col_next    = col;
    rd_next     = rd;
    wp_next     = wp;
    store_we    = 1'b0;
    store_wdata = 8'd1 << cmd.level;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          op_next   = cmd.op;
          step_next = 2'd0;
          col_next  = '0;
          rd_next   = '0;
          if (cmd.op == OP_INIT) begin
            state_next = ST_HEAD;
          end else begin
            state_next = ST_COLS;
          end
          if (cmd.op == OP_SAMPLE) begin
            store_we = 1'b1;
            wp_next  = wrap_inc(wp);
            rd_next  = wrap_inc(wp);
          end
        end
      end
      ST_HEAD: begin
        if (emit) begin
          step_next = step + 2'd1;
          if (step == HEAD_TEST) begin
            state_next = ST_COLS;
          end
        end
      end
      ST_COLS: begin
        if (emit) begin
          col_next = col + 1'b1;
          rd_next  = wrap_inc(rd);
          if (col == LAST_COL) begin
            col_next   = '0;
            state_next = (op == OP_INIT) ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_INIT;
      step  <= 2'd0;
      col   <= '0;
      rd    <= '0;
      wp    <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      step  <= step_next;
      col   <= col_next;
      rd    <= rd_next;
      wp    <= wp_next;
    end
  end

  // Column ring, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLUMNS; i++) begin
        store[i] <= 8'h00;
      end
    end else if (store_we) begin
      store[wp] <= store_wdata;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      oq[oq_wr] <= emit_item;
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_count <= 2'd0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
    end else begin
      if (emit) begin
        oq_wr <= !oq_wr;
      end
      if (take_out) begin
        oq_rd <= !oq_rd;
      end
      case ({emit, take_out})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  assign empty  = (oq_count == 2'd0);
  assign result = oq[oq_rd];

  // Ring pointer stays within the column count
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= LAST_COL) else $error("write pointer beyond last column");

  // Result queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count != 2'd3) else $error("result queue overflow");

  // Final write of a command returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit && emit_item.last |=> state == ST_IDLE)
    else $error("sequencer busy after final write");

endmodule

// ----- sv/scrolling_bar_matrix_driver_top.sv -----
// ----------------------------------------------------------------------------
// scrolling_bar_matrix_driver_top
// Scrolling one-dot graph driver: turns commands into controller writes.
// ----------------------------------------------------------------------------
// Path: the first write of a command reaches the result side through the
//   command queue, then the sequencer, which writes into the result queue.
// Throughput: one write per cycle from the single write path, while the result
//   queue has room; init: head, columns, tail writes; sample, clear: columns.
// Reset: clears queues, column ring and pointer; brightness 8, scan_rows 7.
module scrolling_bar_matrix_driver_top import sbm_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_t                   item,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [3:0] brightness;
  logic [2:0] scan_rows;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RST;
      scan_rows  <= SCAN_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BRIGHTNESS: brightness <= cfg_data[3:0];
        CFG_SCAN_ROWS:  scan_rows  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sbm_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take),
    .brightness (brightness),
    .scan_rows  (scan_rows),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
